// ----- rtl/qte_pkg.sv -----
// Package with the shared types, constants and the arctangent table of the event tracker.
`default_nettype none
package qte_pkg;

    // Sensor kind codes.
    localparam logic [1:0] KIND_ROT   = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ACCEL = 2'd2;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Datapath widths.
    localparam int SUM_W      = 34;
    localparam int CRD_W      = 36;
    localparam int ANG_W      = 29;
    localparam int RAD_W      = 58;
    localparam int ROOT_W     = 29;
    localparam int SQRT_STEPS = 29;
    localparam int ATAN_MAX   = 24;
    localparam int TAB_W      = 25;

    // Half a turn in units of 1/4096 centidegree.
    localparam logic signed [ANG_W-1:0] HALF_TURN = 29'sd73728000;

    // Classification of one event, worked out by the front.
    typedef struct packed {
        logic rot;
        logic gyro;
        logic accel;
        logic known;
    } kind_class_t;

    // One queued event.
    typedef struct packed {
        kind_class_t        cls;
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } event_entry_t;

    // Head of the queue as the back sees it.
    typedef struct packed {
        logic         valid;
        event_entry_t entry;
    } queue_head_t;

    // Sequencer states of the back.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CLAMP,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_PREP,
        ST_ITER,
        ST_FINISH,
        ST_DONE
    } back_state_t;

    // atan(2^-i) in units of 1/4096 centidegree, rounded.
    function automatic logic [TAB_W-1:0] atan_entry(input logic [4:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = 25'd18432000;
            5'd1:    v = 25'd10881045;
            5'd2:    v = 25'd5749245;
            5'd3:    v = 25'd2918407;
            5'd4:    v = 25'd1464867;
            5'd5:    v = 25'd733147;
            5'd6:    v = 25'd366663;
            5'd7:    v = 25'd183343;
            5'd8:    v = 25'd91673;
            5'd9:    v = 25'd45837;
            5'd10:   v = 25'd22918;
            5'd11:   v = 25'd11459;
            5'd12:   v = 25'd5730;
            5'd13:   v = 25'd2865;
            5'd14:   v = 25'd1432;
            5'd15:   v = 25'd716;
            5'd16:   v = 25'd358;
            5'd17:   v = 25'd179;
            5'd18:   v = 25'd90;
            5'd19:   v = 25'd45;
            5'd20:   v = 25'd22;
            5'd21:   v = 25'd11;
            5'd22:   v = 25'd6;
            5'd23:   v = 25'd3;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/qte_if.sv -----
// Stream interfaces for the sensor event channel and the result channel.
`default_nettype none
interface qte_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         sensor_kind;
    logic signed [15:0] comp_w;
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;

    modport source (output valid, sensor_kind, comp_w, comp_x, comp_y, comp_z, input ready);
    modport sink (input valid, sensor_kind, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_centideg;
    logic signed [14:0] pitch_centideg;
    logic signed [15:0] yaw_centideg;
    logic               rotation_valid;
    logic               gyro_valid;
    logic               accel_valid;
    logic               accepted;
    logic [31:0]        event_total;

    modport source (output valid, roll_centideg, pitch_centideg, yaw_centideg,
                    rotation_valid, gyro_valid, accel_valid, accepted, event_total,
                    input ready);
    modport sink (input valid, roll_centideg, pitch_centideg, yaw_centideg,
                  rotation_valid, gyro_valid, accel_valid, accepted, event_total,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/qte_front.sv -----
// Front part: accepts sensor events, classifies them and queues them for the back.
`default_nettype none
module qte_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    qte_in_if.sink              sensor,
    output qte_pkg::queue_head_t head,
    input  wire logic           pop
);

    qte_pkg::event_entry_t         mem [qte_pkg::QUEUE_DEPTH];
    logic [qte_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [qte_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [qte_pkg::QCNT_W-1:0]    count_reg;
    logic [qte_pkg::QCNT_W-1:0]    count_next;
    logic                          push;
    logic                          do_pop;
    qte_pkg::event_entry_t         incoming;

    // A slot is free whenever the queue is not full.
    assign sensor.ready = (count_reg != qte_pkg::QCNT_W'(qte_pkg::QUEUE_DEPTH));
    assign push         = sensor.valid && sensor.ready;
    assign do_pop       = pop && (count_reg != '0);

    // Classify the kind of the incoming event.
    always_comb
    begin
        incoming.cls.rot   = (sensor.sensor_kind == qte_pkg::KIND_ROT);
        incoming.cls.gyro  = (sensor.sensor_kind == qte_pkg::KIND_GYRO);
        incoming.cls.accel = (sensor.sensor_kind == qte_pkg::KIND_ACCEL);
        incoming.cls.known = incoming.cls.rot || incoming.cls.gyro || incoming.cls.accel;
        incoming.w         = sensor.comp_w;
        incoming.x         = sensor.comp_x;
        incoming.y         = sensor.comp_y;
        incoming.z         = sensor.comp_z;
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= incoming;
        end
    end

    // Occupancy count after this cycle's transfers.
    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

`ifndef ASSERT_OFF
    // The occupancy never passes the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= qte_pkg::QCNT_W'(qte_pkg::QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    // A transfer in without one out raises the count by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a transfer");
`endif

endmodule
`default_nettype wire

// ----- rtl/qte_back.sv -----
// Back part: Euler angle sequencer with shared multiplier, square root and CORDIC, and result register.
`default_nettype none
module qte_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire qte_pkg::queue_head_t head,
    output logic                 pop,
    qte_out_if.source            result
);

    localparam int ITERS = (CORDIC_STEPS < qte_pkg::ATAN_MAX) ? CORDIC_STEPS : qte_pkg::ATAN_MAX;
    localparam int SW = qte_pkg::SUM_W;
    localparam int CW = qte_pkg::CRD_W;
    localparam int AW = qte_pkg::ANG_W;
    localparam logic signed [SW-1:0] UNIT = SW'(64'sd268435456);

    qte_pkg::back_state_t  state_reg, state_next;
    qte_pkg::event_entry_t ent_reg;
    logic [4:0]            step_reg;
    logic [1:0]            sel_reg;
    logic signed [31:0]    prod_reg;
    logic [3:0]            ptag_reg;
    logic signed [SW-1:0]  sr_reg, cr_reg, sp_reg, sy_reg, cy_reg;
    logic [qte_pkg::RAD_W-1:0]  rad_reg;
    logic [31:0]                rem_reg;
    logic [qte_pkg::ROOT_W-1:0] root_reg;
    logic signed [CW-1:0]  vx_reg, vy_reg;
    logic signed [AW-1:0]  ang_reg;
    logic signed [15:0]    new_roll_reg, new_pitch_reg, new_yaw_reg;
    logic signed [15:0]    roll_reg, pitch_reg, yaw_reg;
    logic                  rot_seen_reg, gyro_seen_reg, accel_seen_reg;
    logic [31:0]           events_reg;
    logic                  out_valid_reg;

    // Control decoded from the state.
    logic load;
    logic out_free;
    logic mul_last, root_last, iter_last, prep_zero;

    // Datapath intermediates.
    logic signed [15:0]   op_a, op_b;
    logic signed [SW-1:0] p2;
    logic signed [29:0]   sp_c;
    logic signed [59:0]   sp_sq;
    logic [31:0]          rem_t, trial;
    logic signed [SW-1:0] pre_y, pre_x;
    logic signed [CW-1:0] ex_y, ex_x;
    logic signed [CW-1:0] dx, dy;
    logic signed [AW-1:0] tab_v;
    logic signed [29:0]   rsum;
    logic signed [17:0]   rnd, lim, sat;
    logic signed [15:0]   n_roll, n_pitch, n_yaw;
    logic                 n_rot, n_gyro, n_accel;
    logic [31:0]          n_events;

    assign out_free  = !out_valid_reg || result.ready;
    assign mul_last  = (step_reg == 5'd9);
    assign root_last = (step_reg == 5'(qte_pkg::SQRT_STEPS - 1));
    assign iter_last = (step_reg == 5'(ITERS - 1));

    // Operand selection for the nine quaternion products.
    always_comb
    begin
        case (step_reg)
            5'd0:    begin op_a = ent_reg.w; op_b = ent_reg.x; end
            5'd1:    begin op_a = ent_reg.y; op_b = ent_reg.z; end
            5'd2:    begin op_a = ent_reg.w; op_b = ent_reg.y; end
            5'd3:    begin op_a = ent_reg.z; op_b = ent_reg.x; end
            5'd4:    begin op_a = ent_reg.w; op_b = ent_reg.z; end
            5'd5:    begin op_a = ent_reg.x; op_b = ent_reg.y; end
            5'd6:    begin op_a = ent_reg.x; op_b = ent_reg.x; end
            5'd7:    begin op_a = ent_reg.y; op_b = ent_reg.y; end
            5'd8:    begin op_a = ent_reg.z; op_b = ent_reg.z; end
            default: begin op_a = '0;        op_b = '0;        end
        endcase
    end

    // Twice the registered product, extended to the sum width.
    assign p2 = {prod_reg[31], prod_reg, 1'b0};

    // Square of the clamped pitch sine and the square root step.
    assign sp_c  = sp_reg[29:0];
    assign sp_sq = sp_c * sp_c;
    assign rem_t = {rem_reg[29:0], rad_reg[qte_pkg::RAD_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};

    // Vector chosen for the current arctangent.
    always_comb
    begin
        case (sel_reg)
            2'd0:    begin pre_y = sr_reg; pre_x = cr_reg; end
            2'd1:    begin pre_y = sp_reg; pre_x = SW'(root_reg); end
            default: begin pre_y = sy_reg; pre_x = cy_reg; end
        endcase
        ex_y = CW'(pre_y);
        ex_x = CW'(pre_x);
    end
    assign prep_zero = (pre_x == '0) && (pre_y == '0);

    // One CORDIC rotation step.
    assign dx    = vx_reg >>> step_reg;
    assign dy    = vy_reg >>> step_reg;
    assign tab_v = AW'(qte_pkg::atan_entry(step_reg));

    // Rounding to centidegrees and saturation.
    always_comb
    begin
        rsum = 30'(ang_reg) + 30'sd2048;
        rnd  = rsum[29:12];
        lim  = (sel_reg == 2'd1) ? 18'sd9000 : 18'sd18000;
        if (rnd > lim)
        begin
            sat = lim;
        end
        else if (rnd < -lim)
        begin
            sat = -lim;
        end
        else
        begin
            sat = rnd;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qte_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = head.entry.cls.rot ? qte_pkg::ST_MUL : qte_pkg::ST_DONE;
                end
            end
            qte_pkg::ST_MUL:       state_next = mul_last ? qte_pkg::ST_CLAMP : qte_pkg::ST_MUL;
            qte_pkg::ST_CLAMP:     state_next = qte_pkg::ST_ROOT_LOAD;
            qte_pkg::ST_ROOT_LOAD: state_next = qte_pkg::ST_ROOT;
            qte_pkg::ST_ROOT:      state_next = root_last ? qte_pkg::ST_PREP : qte_pkg::ST_ROOT;
            qte_pkg::ST_PREP:      state_next = prep_zero ? qte_pkg::ST_FINISH : qte_pkg::ST_ITER;
            qte_pkg::ST_ITER:      state_next = iter_last ? qte_pkg::ST_FINISH : qte_pkg::ST_ITER;
            qte_pkg::ST_FINISH:
            begin
                state_next = (sel_reg == 2'd2) ? qte_pkg::ST_DONE : qte_pkg::ST_PREP;
            end
            qte_pkg::ST_DONE:      state_next = out_free ? qte_pkg::ST_IDLE : qte_pkg::ST_DONE;
            default:               state_next = qte_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        case (state_reg)
            qte_pkg::ST_IDLE: pop  = head.valid;
            qte_pkg::ST_DONE: load = out_free;
            default:
            begin
                pop  = 1'b0;
                load = 1'b0;
            end
        endcase
    end

    // Tracker state after the current event is committed.
    always_comb
    begin
        n_roll   = ent_reg.cls.rot ? new_roll_reg : roll_reg;
        n_pitch  = ent_reg.cls.rot ? new_pitch_reg : pitch_reg;
        n_yaw    = ent_reg.cls.rot ? new_yaw_reg : yaw_reg;
        n_rot    = rot_seen_reg || ent_reg.cls.rot;
        n_gyro   = gyro_seen_reg || ent_reg.cls.gyro;
        n_accel  = accel_seen_reg || ent_reg.cls.accel;
        n_events = events_reg + 32'(ent_reg.cls.known);
    end

    // Arithmetic datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            qte_pkg::ST_IDLE:
            begin
                ent_reg  <= head.entry;
                step_reg <= '0;
                sr_reg   <= '0;
                cr_reg   <= UNIT;
                sp_reg   <= '0;
                sy_reg   <= '0;
                cy_reg   <= UNIT;
            end
            qte_pkg::ST_MUL:
            begin
                // One product a cycle, folded in the cycle after.
                prod_reg <= op_a * op_b;
                ptag_reg <= step_reg[3:0];
                step_reg <= step_reg + 1'b1;
                if (step_reg != '0)
                begin
                    case (ptag_reg)
                        4'd0, 4'd1: sr_reg <= sr_reg + p2;
                        4'd2:       sp_reg <= sp_reg + p2;
                        4'd3:       sp_reg <= sp_reg - p2;
                        4'd4, 4'd5: sy_reg <= sy_reg + p2;
                        4'd6:       cr_reg <= cr_reg - p2;
                        4'd7:
                        begin
                            cr_reg <= cr_reg - p2;
                            cy_reg <= cy_reg - p2;
                        end
                        default:    cy_reg <= cy_reg - p2;
                    endcase
                end
            end
            qte_pkg::ST_CLAMP:
            begin
                if (sp_reg > UNIT)
                begin
                    sp_reg <= UNIT;
                end
                else if (sp_reg < -UNIT)
                begin
                    sp_reg <= -UNIT;
                end
            end
            qte_pkg::ST_ROOT_LOAD:
            begin
                rad_reg  <= (qte_pkg::RAD_W'(1) << 56) - sp_sq[qte_pkg::RAD_W-1:0];
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
                sel_reg  <= 2'd0;
            end
            qte_pkg::ST_ROOT:
            begin
                // One result bit per cycle, two radicand bits consumed.
                rad_reg  <= rad_reg << 2;
                step_reg <= step_reg + 1'b1;
                if (rem_t >= trial)
                begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[qte_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[qte_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            qte_pkg::ST_PREP:
            begin
                // Fold the left half plane onto the right one.
                step_reg <= '0;
                if (prep_zero)
                begin
                    ang_reg <= '0;
                end
                else if (ex_x < 0)
                begin
                    vx_reg  <= -ex_x;
                    vy_reg  <= -ex_y;
                    ang_reg <= (ex_y >= 0) ? qte_pkg::HALF_TURN : -qte_pkg::HALF_TURN;
                end
                else
                begin
                    vx_reg  <= ex_x;
                    vy_reg  <= ex_y;
                    ang_reg <= '0;
                end
            end
            qte_pkg::ST_ITER:
            begin
                step_reg <= step_reg + 1'b1;
                if (vy_reg >= 0)
                begin
                    vx_reg  <= vx_reg + dy;
                    vy_reg  <= vy_reg - dx;
                    ang_reg <= ang_reg + tab_v;
                end
                else
                begin
                    vx_reg  <= vx_reg - dy;
                    vy_reg  <= vy_reg + dx;
                    ang_reg <= ang_reg - tab_v;
                end
            end
            qte_pkg::ST_FINISH:
            begin
                case (sel_reg)
                    2'd0:    new_roll_reg  <= sat[15:0];
                    2'd1:    new_pitch_reg <= sat[15:0];
                    default: new_yaw_reg   <= sat[15:0];
                endcase
                sel_reg <= sel_reg + 1'b1;
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    // Held tracker state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qte_pkg::ST_IDLE;
            roll_reg       <= '0;
            pitch_reg      <= '0;
            yaw_reg        <= '0;
            rot_seen_reg   <= 1'b0;
            gyro_seen_reg  <= 1'b0;
            accel_seen_reg <= 1'b0;
            events_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                roll_reg       <= n_roll;
                pitch_reg      <= n_pitch;
                yaw_reg        <= n_yaw;
                rot_seen_reg   <= n_rot;
                gyro_seen_reg  <= n_gyro;
                accel_seen_reg <= n_accel;
                events_reg     <= n_events;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, captured with the commit.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result.roll_centideg  <= n_roll;
            result.pitch_centideg <= n_pitch[14:0];
            result.yaw_centideg   <= n_yaw;
            result.rotation_valid <= n_rot;
            result.gyro_valid     <= n_gyro;
            result.accel_valid    <= n_accel;
            result.accepted       <= ent_reg.cls.known;
            result.event_total    <= n_events;
        end
    end

    assign result.valid = out_valid_reg;

`ifndef ASSERT_OFF
    // An ignored event leaves the counter alone.
    a_ignored_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !ent_reg.cls.known) |=> $stable(events_reg))
        else $error("ignored event changed the counter");

    // Held angles stay inside their saturation limits.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (roll_reg <= 16'sd18000) && (roll_reg >= -16'sd18000) &&
        (pitch_reg <= 16'sd9000) && (pitch_reg >= -16'sd9000) &&
        (yaw_reg <= 16'sd18000) && (yaw_reg >= -16'sd18000))
        else $error("held angle out of range");

    // A new event is taken from the queue only when the sequencer is idle.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == qte_pkg::ST_IDLE) && head.valid)
        else $error("queue popped outside idle");

    // The CORDIC step count stays within the iteration range.
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qte_pkg::ST_ITER) |-> (step_reg <= 5'(ITERS - 1)))
        else $error("CORDIC step past its end");
`endif

endmodule
`default_nettype wire

// ----- rtl/quaternion_to_euler_event_tracker_unit.sv -----
// Top level of the quaternion to Euler event tracker.
// Usage:
//   The sensor channel takes one event per transfer: a kind code and four Q1.14
//   components. Every event gives exactly one transfer on the result channel,
//   carrying the held roll, pitch and yaw in centidegrees, the seen flags, the
//   recognised flag and the wrapping event count after that event.
//   Events pass through a two-entry queue to a sequencer that handles one at a
//   time and takes each event from the queue in its idle state. Gyroscope,
//   accelerometer and ignored events skip the arithmetic. A rotation event runs
//   its products on the shared multiplier, then the clamp and square, the square
//   root and three arctangents on the shared CORDIC unit.
//   At reset the angles, flags and counter clear to zero and both channels
//   empty. When the receiver stalls, the result register holds its transfer,
//   the sequencer waits with the next result, and the queue goes on taking
//   events until it is full, then drops ready.
`default_nettype none
module quaternion_to_euler_event_tracker_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    qte_in_if.sink    sensor,
    qte_out_if.source result
);

    qte_pkg::queue_head_t head;
    logic                 pop;

    qte_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sensor (sensor),
        .head   (head),
        .pop    (pop)
    );

    qte_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire
